// ===== hdl/pbrw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbrw_pkg
// Types, codes and constants of the base-relocation walker.
// ----------------------------------------------------------------------------
package pbrw_pkg;

    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_IDX_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    localparam logic [31:0] HEADER_BYTES = 32'd8;
    localparam logic [15:0] OFFSET_MASK  = 16'h0fff;
    localparam int unsigned TYPE_SHIFT   = 12;
    localparam logic [3:0]  TYPE_ABSOLUTE = 4'd0;
    localparam logic [3:0]  TYPE_DIR64    = 4'd10;

    typedef enum logic [1:0] {
        REG_IMAGE_BYTES = 2'd0,
        REG_DIR_ADDRESS = 2'd1,
        REG_DIR_SIZE    = 2'd2,
        REG_DELTA       = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_HWORD = 2'd0,
        CMD_VALUE = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FORMAT = 2'd1,
        ST_RELOC_FAIL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_ENTRY  = 2'd2,
        PH_WAIT   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [63:0] value;
        logic [1:0]  status;
        logic        last;
    } res_t;

    function automatic logic in_image(input logic [31:0] addr, input logic [31:0] len,
                                      input logic [31:0] size);
        return (addr <= size) && (len <= (size - addr));
    endfunction

endpackage

// ===== hdl/pe_base_relocation_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pe_base_relocation_walker
// Walks a DIR64 base-relocation directory and issues read, patch and finish beats.
// ----------------------------------------------------------------------------
// Usage:
//   Load image_bytes, dir_address, dir_size and delta over the APB port
//   (byte addresses 0, 8, 16, 24) while the block is idle, then send a start
//   beat (s_tuser = 2). Directory halfwords follow as s_tuser = 0 beats; each
//   DIR64 entry yields a read request on the master side, answered by an
//   s_tuser = 1 beat carrying the old word, which yields a write beat with
//   old + delta. A finish beat with a status ends every run.
// Timing:
//   Results of a beat are registered in the result queue before they reach
//   the master side. One input beat is taken every cycle while s_tready is
//   high; a beat that causes two results (write plus finish) pushes both at
//   once. A four-entry result queue sits between the two sides, so input
//   keeps flowing while a result waits; s_tready drops while three or more
//   results are queued, i.e. once a stalled receiver has let results pile up.
// Reset:
//   Clears all control registers to zero, empties the queue and puts the walker idle.
// ----------------------------------------------------------------------------
module pe_base_relocation_walker
(
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbrw_pkg::ADDR_W-1:0]       paddr,
    input  logic [63:0]                       pwdata,
    output logic [63:0]                       prdata,
    output logic                              pready,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pbrw_pkg::IN_DATA_W-1:0]    s_tdata,   // halfword[15:0], old_value[79:16]
    input  logic [1:0]                        s_tuser,   // cmd[1:0]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pbrw_pkg::OUT_DATA_W-1:0]   m_tdata,   // address[31:0], value[95:32],
                                                         // status[97:96], zero[103:98]
    output logic [1:0]                        m_tuser,   // kind[1:0]
    output logic                              m_tlast
);

    logic [31:0] image_bytes_reg;
    logic [31:0] dir_address_reg;
    logic [31:0] dir_size_reg;
    logic [63:0] delta_reg;

    pbrw_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  slot_reg, slot_next;
    logic [31:0] page_reg, page_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [31:0] pending_reg, pending_next;

    pbrw_pkg::res_t fifo_mem [pbrw_pkg::FIFO_DEPTH];
    logic [pbrw_pkg::FIFO_IDX_W-1:0] head_reg, head_next;
    logic [pbrw_pkg::FIFO_IDX_W-1:0] tail_reg, tail_next;
    logic [pbrw_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    logic           s_acc;
    logic           m_acc;
    logic           cfg_wr;
    logic [1:0]     cmd;
    logic [15:0]    hw;
    logic [63:0]    old_value;
    logic [31:0]    consumed_inc;
    logic [31:0]    hdr_size;
    logic [31:0]    entry_left;
    logic [3:0]     entry_type;
    logic [11:0]    entry_off;
    logic [32:0]    target_sum;
    logic [31:0]    bnd_c;
    logic           bnd_fin;
    pbrw_pkg::status_t bnd_status;
    pbrw_pkg::res_t r0, r1;
    logic [1:0]     push_n;
    pbrw_pkg::res_t head_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_bytes_reg <= '0;
            dir_address_reg <= '0;
            dir_size_reg    <= '0;
            delta_reg       <= '0;
        end
        else if (cfg_wr)
        begin
            case (pbrw_pkg::reg_idx_t'(paddr[4:3]))
                pbrw_pkg::REG_IMAGE_BYTES: image_bytes_reg <= pwdata[31:0];
                pbrw_pkg::REG_DIR_ADDRESS: dir_address_reg <= pwdata[31:0];
                pbrw_pkg::REG_DIR_SIZE:    dir_size_reg    <= pwdata[31:0];
                pbrw_pkg::REG_DELTA:       delta_reg       <= pwdata;
                default:                   delta_reg       <= delta_reg;
            endcase
        end
    end

    always_comb
    begin
        case (pbrw_pkg::reg_idx_t'(paddr[4:3]))
            pbrw_pkg::REG_IMAGE_BYTES: prdata = {32'h0, image_bytes_reg};
            pbrw_pkg::REG_DIR_ADDRESS: prdata = {32'h0, dir_address_reg};
            pbrw_pkg::REG_DIR_SIZE:    prdata = {32'h0, dir_size_reg};
            pbrw_pkg::REG_DELTA:       prdata = delta_reg;
            default:                   prdata = '0;
        endcase
    end

    assign s_tready  = (count_reg <= pbrw_pkg::FIFO_CNT_W'(pbrw_pkg::FIFO_DEPTH - 2));
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign cmd       = s_tuser;
    assign hw        = s_tdata[15:0];
    assign old_value = s_tdata[79:16];

    assign consumed_inc = consumed_reg + 32'd2;
    assign hdr_size     = left_reg | {hw, 16'h0};
    assign entry_left   = left_reg - 32'd2;
    assign entry_type   = hw[15:pbrw_pkg::TYPE_SHIFT];
    assign entry_off    = hw[11:0] & pbrw_pkg::OFFSET_MASK[11:0];
    assign target_sum   = {1'b0, page_reg} + {21'h0, entry_off};

    // block boundary: end of directory, short tail, or next header
    always_comb
    begin
        case (pbrw_pkg::cmd_t'(cmd))
            pbrw_pkg::CMD_START: bnd_c = 32'h0;
            pbrw_pkg::CMD_HWORD: bnd_c = consumed_inc;
            default:             bnd_c = consumed_reg;
        endcase
        bnd_fin    = 1'b1;
        bnd_status = pbrw_pkg::ST_OK;
        if (bnd_c == dir_size_reg)
            bnd_status = pbrw_pkg::ST_OK;
        else if ((dir_size_reg - bnd_c) < pbrw_pkg::HEADER_BYTES)
            bnd_status = pbrw_pkg::ST_BAD_FORMAT;
        else
            bnd_fin = 1'b0;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        slot_next     = slot_reg;
        page_next     = page_reg;
        left_next     = left_reg;
        consumed_next = consumed_reg;
        pending_next  = pending_reg;
        r0            = '0;
        r1            = '0;
        push_n        = 2'd0;
        if (s_acc)
        begin
            case (pbrw_pkg::cmd_t'(cmd))
                pbrw_pkg::CMD_START:
                begin
                    slot_next     = 2'd0;
                    page_next     = '0;
                    left_next     = '0;
                    consumed_next = '0;
                    pending_next  = '0;
                    push_n        = 2'd1;
                    r0.kind       = pbrw_pkg::KIND_FINISH;
                    phase_next    = pbrw_pkg::PH_IDLE;
                    if (delta_reg == 64'h0)
                        r0.status = pbrw_pkg::ST_OK;
                    else if (dir_address_reg == 32'h0 || dir_size_reg == 32'h0 ||
                             !pbrw_pkg::in_image(dir_address_reg, dir_size_reg,
                                                 image_bytes_reg))
                        r0.status = pbrw_pkg::ST_RELOC_FAIL;
                    else if (bnd_fin)
                        r0.status = bnd_status;
                    else
                    begin
                        push_n     = 2'd0;
                        phase_next = pbrw_pkg::PH_HEADER;
                    end
                end
                pbrw_pkg::CMD_HWORD:
                begin
                    if (phase_reg == pbrw_pkg::PH_HEADER)
                    begin
                        consumed_next = consumed_inc;
                        case (slot_reg)
                            2'd0:    page_next = {16'h0, hw};
                            2'd1:    page_next = page_reg | {hw, 16'h0};
                            2'd2:    left_next = {16'h0, hw};
                            default: left_next = hdr_size;
                        endcase
                        if (slot_reg != 2'd3)
                            slot_next = slot_reg + 2'd1;
                        else
                        begin
                            slot_next = 2'd0;
                            r0.kind   = pbrw_pkg::KIND_FINISH;
                            if (hdr_size < pbrw_pkg::HEADER_BYTES || hdr_size[0] ||
                                (hdr_size - pbrw_pkg::HEADER_BYTES) >
                                (dir_size_reg - consumed_inc))
                            begin
                                push_n     = 2'd1;
                                r0.status  = pbrw_pkg::ST_BAD_FORMAT;
                                phase_next = pbrw_pkg::PH_IDLE;
                            end
                            else
                            begin
                                left_next = hdr_size - pbrw_pkg::HEADER_BYTES;
                                if (hdr_size != pbrw_pkg::HEADER_BYTES)
                                    phase_next = pbrw_pkg::PH_ENTRY;
                                else if (bnd_fin)
                                begin
                                    push_n     = 2'd1;
                                    r0.status  = bnd_status;
                                    phase_next = pbrw_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = pbrw_pkg::PH_HEADER;
                                    left_next  = '0;
                                end
                            end
                        end
                    end
                    else if (phase_reg == pbrw_pkg::PH_ENTRY)
                    begin
                        consumed_next = consumed_inc;
                        left_next     = entry_left;
                        r0.kind       = pbrw_pkg::KIND_FINISH;
                        if (entry_type == pbrw_pkg::TYPE_ABSOLUTE)
                        begin
                            if (entry_left == 32'h0)
                            begin
                                if (bnd_fin)
                                begin
                                    push_n     = 2'd1;
                                    r0.status  = bnd_status;
                                    phase_next = pbrw_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = pbrw_pkg::PH_HEADER;
                                    slot_next  = 2'd0;
                                    left_next  = '0;
                                end
                            end
                        end
                        else if (entry_type != pbrw_pkg::TYPE_DIR64 || target_sum[32])
                        begin
                            push_n     = 2'd1;
                            r0.status  = pbrw_pkg::ST_RELOC_FAIL;
                            phase_next = pbrw_pkg::PH_IDLE;
                        end
                        else if (!pbrw_pkg::in_image(target_sum[31:0], 32'd8, image_bytes_reg))
                        begin
                            push_n     = 2'd1;
                            r0.status  = pbrw_pkg::ST_BAD_FORMAT;
                            phase_next = pbrw_pkg::PH_IDLE;
                        end
                        else
                        begin
                            push_n       = 2'd1;
                            r0.kind      = pbrw_pkg::KIND_READ;
                            r0.address   = target_sum[31:0];
                            pending_next = target_sum[31:0];
                            phase_next   = pbrw_pkg::PH_WAIT;
                        end
                    end
                end
                pbrw_pkg::CMD_VALUE:
                begin
                    if (phase_reg == pbrw_pkg::PH_WAIT)
                    begin
                        push_n     = 2'd1;
                        r0.kind    = pbrw_pkg::KIND_WRITE;
                        r0.address = pending_reg;
                        r0.value   = old_value + delta_reg;
                        phase_next = pbrw_pkg::PH_ENTRY;
                        r1.kind    = pbrw_pkg::KIND_FINISH;
                        if (left_reg == 32'h0)
                        begin
                            if (bnd_fin)
                            begin
                                push_n     = 2'd2;
                                r1.status  = bnd_status;
                                phase_next = pbrw_pkg::PH_IDLE;
                            end
                            else
                            begin
                                phase_next = pbrw_pkg::PH_HEADER;
                                slot_next  = 2'd0;
                                left_next  = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    push_n = 2'd0;
                end
            endcase
        end
        r0.last = (push_n == 2'd1);
        r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= pbrw_pkg::PH_IDLE;
            slot_reg     <= '0;
            page_reg     <= '0;
            left_reg     <= '0;
            consumed_reg <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            slot_reg     <= slot_next;
            page_reg     <= page_next;
            left_reg     <= left_next;
            consumed_reg <= consumed_next;
            pending_reg  <= pending_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_mem[tail_reg] <= r0;
        if (push_n == 2'd2)
            fifo_mem[tail_reg + 2'd1] <= r1;
    end

    always_comb
    begin
        tail_next  = tail_reg + push_n;
        head_next  = head_reg + {1'b0, m_acc};
        count_next = count_reg + {1'b0, push_n} - {2'b0, m_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign head_res = fifo_mem[head_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {6'h0, head_res.status, head_res.value, head_res.address};
    assign m_tuser  = head_res.kind;
    assign m_tlast  = head_res.last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pbrw_pkg::FIFO_CNT_W'(pbrw_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        push_n == 2'd2 |-> r0.kind == pbrw_pkg::KIND_WRITE &&
                           r1.kind == pbrw_pkg::KIND_FINISH)
        else $error("two-result beat is not write plus finish");

    a_zero_delta: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && cmd == pbrw_pkg::CMD_START && delta_reg == 64'h0
        |=> phase_reg == pbrw_pkg::PH_IDLE && count_reg != '0)
        else $error("zero delta start did not finish");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_n != 2'd0 |-> s_acc)
        else $error("result pushed without an accepted beat");
`endif

endmodule

// ===== test/reloc_walk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reloc_walk_checker
// Tracks register writes over APB, predicts the read, patch and finish beats
// that each accepted input beat of the relocation walker causes, and compares
// every result beat in order, field by field, against that prediction.
// ----------------------------------------------------------------------------
module reloc_walk_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [pbrw_pkg::ADDR_W-1:0]         paddr,
    input  logic [63:0]                         pwdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [pbrw_pkg::IN_DATA_W-1:0]      s_tdata,   // halfword[15:0], old_value[79:16]
    input  logic [1:0]                          s_tuser,   // cmd[1:0]
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [pbrw_pkg::OUT_DATA_W-1:0]     m_tdata,   // address[31:0], value[95:32],
                                                           // status[97:96]
    input  logic [1:0]                          m_tuser,   // kind[1:0]
    input  logic                                m_tlast,
    output int                                  mismatch_total,
    output int                                  backlog,
    output int                                  patch_total,
    output int                                  finish_total
);

    typedef struct {
        pbrw_pkg::kind_t   kind;
        logic [31:0]       address;
        logic [63:0]       value;
        pbrw_pkg::status_t status;
        logic              last;
    } reloc_beat_t;

    logic [31:0] cfg_image;
    logic [31:0] cfg_dir_addr;
    logic [31:0] cfg_dir_size;
    logic [63:0] cfg_delta;

    pbrw_pkg::phase_t walk_phase;
    logic [1:0]  hdr_slot;
    logic [31:0] page_base;
    logic [31:0] block_left;
    logic [31:0] dir_used;
    logic [31:0] read_target;

    reloc_beat_t step_beats[$];
    reloc_beat_t expected_beats[$];
    int          fails;
    int          patches;
    int          finishes;

    function automatic void emit(input pbrw_pkg::kind_t k, input logic [31:0] a,
                                 input logic [63:0] v, input pbrw_pkg::status_t s);
        reloc_beat_t b;
        b.kind    = k;
        b.address = a;
        b.value   = v;
        b.status  = s;
        b.last    = 1'b0;
        step_beats.push_back(b);
    endfunction

    function automatic void end_run(input pbrw_pkg::status_t s);
        walk_phase = pbrw_pkg::PH_IDLE;
        emit(pbrw_pkg::KIND_FINISH, 32'd0, 64'd0, s);
    endfunction

    function automatic logic fits_image(input logic [31:0] a, input logic [31:0] len);
        return (a <= cfg_image) && (len <= cfg_image - a);
    endfunction

    // Close the run at the directory end or on a short tail, else wait for the next header.
    function automatic void next_block();
        if (dir_used == cfg_dir_size)
            end_run(pbrw_pkg::ST_OK);
        else if (cfg_dir_size - dir_used < pbrw_pkg::HEADER_BYTES)
            end_run(pbrw_pkg::ST_BAD_FORMAT);
        else
        begin
            walk_phase = pbrw_pkg::PH_HEADER;
            hdr_slot   = 2'd0;
            block_left = 32'd0;
        end
    endfunction

    function automatic void take_halfword(input logic [15:0] hw);
        logic [3:0]  etype;
        logic [31:0] offs;
        if (walk_phase == pbrw_pkg::PH_HEADER)
        begin
            dir_used = dir_used + 32'd2;
            case (hdr_slot)
                2'd0: page_base = {16'h0000, hw};
                2'd1: page_base[31:16] = hw;
                2'd2: block_left = {16'h0000, hw};
                default: block_left[31:16] = hw;
            endcase
            if (hdr_slot != 2'd3)
                hdr_slot = hdr_slot + 2'd1;
            else
            begin
                hdr_slot = 2'd0;
                if (block_left < pbrw_pkg::HEADER_BYTES || block_left[0] ||
                    block_left - pbrw_pkg::HEADER_BYTES > cfg_dir_size - dir_used)
                    end_run(pbrw_pkg::ST_BAD_FORMAT);
                else
                begin
                    block_left = block_left - pbrw_pkg::HEADER_BYTES;
                    if (block_left == 32'd0)
                        next_block();
                    else
                        walk_phase = pbrw_pkg::PH_ENTRY;
                end
            end
        end
        else if (walk_phase == pbrw_pkg::PH_ENTRY)
        begin
            etype      = hw[15:12];
            offs       = {20'h00000, hw[11:0]};
            dir_used   = dir_used + 32'd2;
            block_left = block_left - 32'd2;
            if (etype == pbrw_pkg::TYPE_ABSOLUTE)
            begin
                if (block_left == 32'd0)
                    next_block();
            end
            else if (etype != pbrw_pkg::TYPE_DIR64 || page_base > 32'hffff_ffff - offs)
                end_run(pbrw_pkg::ST_RELOC_FAIL);
            else if (!fits_image(page_base + offs, 32'd8))
                end_run(pbrw_pkg::ST_BAD_FORMAT);
            else
            begin
                read_target = page_base + offs;
                walk_phase  = pbrw_pkg::PH_WAIT;
                emit(pbrw_pkg::KIND_READ, read_target, 64'd0, pbrw_pkg::ST_OK);
            end
        end
    endfunction

    function automatic void walk_step(input logic [1:0] cmd, input logic [15:0] hw,
                                      input logic [63:0] old);
        reloc_beat_t b;
        step_beats.delete();
        if (cmd == pbrw_pkg::CMD_START)
        begin
            hdr_slot    = 2'd0;
            page_base   = 32'd0;
            block_left  = 32'd0;
            dir_used    = 32'd0;
            read_target = 32'd0;
            if (cfg_delta == 64'd0)
                end_run(pbrw_pkg::ST_OK);
            else if (cfg_dir_addr == 32'd0 || cfg_dir_size == 32'd0 ||
                     !fits_image(cfg_dir_addr, cfg_dir_size))
                end_run(pbrw_pkg::ST_RELOC_FAIL);
            else
                next_block();
        end
        else if (cmd == pbrw_pkg::CMD_HWORD)
            take_halfword(hw);
        else if (cmd == pbrw_pkg::CMD_VALUE && walk_phase == pbrw_pkg::PH_WAIT)
        begin
            emit(pbrw_pkg::KIND_WRITE, read_target, old + cfg_delta, pbrw_pkg::ST_OK);
            walk_phase = pbrw_pkg::PH_ENTRY;
            if (block_left == 32'd0)
                next_block();
        end
        foreach (step_beats[i])
        begin
            b      = step_beats[i];
            b.last = (i == step_beats.size() - 1);
            expected_beats.push_back(b);
        end
    endfunction

    function automatic void flag(input string field, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        fails++;
        $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reloc_beat_t want;
        if (!rst_n)
        begin
            cfg_image    = 32'd0;
            cfg_dir_addr = 32'd0;
            cfg_dir_size = 32'd0;
            cfg_delta    = 64'd0;
            walk_phase   = pbrw_pkg::PH_IDLE;
            hdr_slot     = 2'd0;
            page_base    = 32'd0;
            block_left   = 32'd0;
            dir_used     = 32'd0;
            read_target  = 32'd0;
            expected_beats.delete();
            fails        = 0;
            patches      = 0;
            finishes     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (pbrw_pkg::reg_idx_t'(paddr[4:3]))
                    pbrw_pkg::REG_IMAGE_BYTES: cfg_image    = pwdata[31:0];
                    pbrw_pkg::REG_DIR_ADDRESS: cfg_dir_addr = pwdata[31:0];
                    pbrw_pkg::REG_DIR_SIZE:    cfg_dir_size = pwdata[31:0];
                    default:                   cfg_delta    = pwdata;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    fails++;
                    $error("unexpected result beat: kind %0d address 0x%0h",
                           m_tuser, m_tdata[31:0]);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_tuser !== want.kind)
                        flag("kind", want.kind, m_tuser);
                    if (m_tdata[31:0] !== want.address)
                        flag("address", want.address, m_tdata[31:0]);
                    if (m_tdata[95:32] !== want.value)
                        flag("value", want.value, m_tdata[95:32]);
                    if (m_tdata[97:96] !== want.status)
                        flag("status", want.status, m_tdata[97:96]);
                    if (m_tlast !== want.last)
                        flag("last", want.last, m_tlast);
                    if (want.kind == pbrw_pkg::KIND_WRITE)
                        patches++;
                    if (want.kind == pbrw_pkg::KIND_FINISH)
                        finishes++;
                end
            end
            if (s_tvalid && s_tready)
                walk_step(s_tuser, s_tdata[15:0], s_tdata[79:16]);
        end
        mismatch_total <= fails;
        backlog        <= expected_beats.size();
        patch_total    <= patches;
        finish_total   <= finishes;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the relocation walker with directed corner runs, then with random
// directories that are mostly well formed (blocks of DIR64 and padding
// entries, each read answered with an old word) and partly corrupted, under
// several register settings and random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int         RANDOM_BEATS = 1150;
    localparam int         PHASES       = 6;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] hw;
        logic [63:0] old;
    } beat_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [pbrw_pkg::ADDR_W-1:0]         paddr;
    logic [63:0]                         pwdata;
    logic [63:0]                         prdata;
    logic                                pready;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [pbrw_pkg::IN_DATA_W-1:0]      s_tdata;
    logic [1:0]                          s_tuser;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [pbrw_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic [1:0]                          m_tuser;
    logic                                m_tlast;

    int          mismatch_total;
    int          backlog;
    int          patch_total;
    int          finish_total;

    beat_t       run_beats[$];
    logic [31:0] img_size;
    int          beats_sent;
    int          runs_sent;
    int          settings_used;
    logic        src_steady;
    logic        sink_steady;
    int          stall_left = 0;

    pe_base_relocation_walker DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    reloc_walk_checker scoreboard
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_total (mismatch_total),
        .backlog        (backlog),
        .patch_total    (patch_total),
        .finish_total   (finish_total)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: mostly ready, short stalls, now and then a long one.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (sink_steady || $urandom_range(0, 9) < 7)
            m_tready <= 1'b1;
        else
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                       : $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end
    end

    function automatic int source_gap();
        int r;
        if (src_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_beat(input logic [1:0] cmd, input logic [15:0] hw,
                             input logic [63:0] old);
        int gap;
        gap = source_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {old, hw};
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic write_reg(input pbrw_pkg::reg_idx_t idx, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every predicted beat, then let the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (backlog != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void queue_beat(input logic [1:0] cmd, input logic [15:0] hw,
                                       input logic [63:0] old);
        beat_t b;
        b.cmd = cmd;
        b.hw  = hw;
        b.old = old;
        run_beats.push_back(b);
    endfunction

    function automatic logic [63:0] random_word();
        if ($urandom_range(0, 9) == 0)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Build one directory run; return the byte length the blocks really take.
    function automatic logic [31:0] build_run();
        int          nblk;
        int          nent;
        int          r;
        logic [31:0] page;
        logic [31:0] size;
        logic [31:0] total;
        logic [3:0]  etype;
        run_beats.delete();
        total = 32'd0;
        queue_beat(pbrw_pkg::CMD_START, 16'($urandom), random_word());
        nblk = $urandom_range(1, 3);
        repeat (nblk)
        begin
            nent = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            r = $urandom_range(0, 19);
            if (r == 0)
                page = 32'hffff_ff00 | $urandom_range(0, 255);
            else if (r == 1)
                page = img_size - $urandom_range(0, 32'h1000);
            else
                page = $urandom_range(0, img_size - 32'h1008);
            size = 32'd8 + 32'(2 * nent);
            r = $urandom_range(0, 29);
            if (r == 0)
                size = size | 32'd1;
            else if (r == 1)
                size = $urandom_range(0, 7);
            else if (r == 2)
                size = size + 32'h1000;
            else if (r == 3)
                size = $urandom;
            queue_beat(pbrw_pkg::CMD_HWORD, page[15:0], random_word());
            queue_beat(pbrw_pkg::CMD_HWORD, page[31:16], random_word());
            queue_beat(pbrw_pkg::CMD_HWORD, size[15:0], random_word());
            queue_beat(pbrw_pkg::CMD_HWORD, size[31:16], random_word());
            total = total + 32'd8 + 32'(2 * nent);
            repeat (nent)
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    etype = pbrw_pkg::TYPE_DIR64;
                else if (r < 88)
                    etype = pbrw_pkg::TYPE_ABSOLUTE;
                else
                begin
                    etype = 4'($urandom_range(1, 15));
                    if (etype == pbrw_pkg::TYPE_DIR64)
                        etype = 4'hf;
                end
                queue_beat(pbrw_pkg::CMD_HWORD, {etype, 12'($urandom)}, random_word());
                if (etype == pbrw_pkg::TYPE_DIR64)
                    queue_beat(pbrw_pkg::CMD_VALUE, 16'($urandom), random_word());
                r = $urandom_range(0, 59);
                if (r == 0)
                    queue_beat(pbrw_pkg::CMD_START, 16'($urandom), random_word());
                else if (r <= 2)
                    queue_beat(CMD_RESERVED, 16'($urandom), random_word());
                else if (r <= 4)
                    queue_beat(pbrw_pkg::CMD_VALUE, 16'($urandom), random_word());
                else if (r == 5)
                    queue_beat(pbrw_pkg::CMD_HWORD, 16'($urandom), random_word());
            end
        end
        return total;
    endfunction

    task automatic play_run();
        logic [31:0] span;
        logic [31:0] where;
        int          r;
        span = build_run();
        r = $urandom_range(0, 39);
        if (r < 3)
            span = span + 32'(2 * $urandom_range(1, 3));
        else if (r < 5 && span > 32'd8)
            span = span - 32'(2 * $urandom_range(1, 4));
        else if (r == 5)
            span = 32'd0;
        r = $urandom_range(0, 29);
        if (r == 0)
            where = 32'd0;
        else if (r == 1)
            where = img_size - $urandom_range(0, 7);
        else
            where = $urandom_range(1, img_size >> 1);
        settle();
        write_reg(pbrw_pkg::REG_DIR_SIZE, {32'd0, span});
        write_reg(pbrw_pkg::REG_DIR_ADDRESS, {32'd0, where});
        src_steady  = ($urandom_range(0, 4) == 0);
        sink_steady <= ($urandom_range(0, 4) == 0);
        foreach (run_beats[i])
            push_beat(run_beats[i].cmd, run_beats[i].hw, run_beats[i].old);
        runs_sent++;
    endtask

    initial
    begin
        int          directed_beats;
        logic [63:0] delta_val;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= pbrw_pkg::CMD_HWORD;
        sink_steady <= 1'b0;
        src_steady  = 1'b0;
        beats_sent  = 0;
        runs_sent   = 0;
        settings_used = 1;
        img_size    = 32'h0001_0000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero delta, then beats the idle walker must ignore
        push_beat(pbrw_pkg::CMD_START, 16'h0000, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, 16'hffff, 64'd0);
        push_beat(pbrw_pkg::CMD_VALUE, 16'h0000, '1);
        push_beat(CMD_RESERVED, 16'h5a5a, 64'd0);
        settle();
        write_reg(pbrw_pkg::REG_IMAGE_BYTES, 64'h0000_0000_0001_0000);
        write_reg(pbrw_pkg::REG_DELTA, '1);
        write_reg(pbrw_pkg::REG_DIR_SIZE, 64'd16);
        write_reg(pbrw_pkg::REG_DIR_ADDRESS, 64'd0);
        push_beat(pbrw_pkg::CMD_START, 16'h0000, 64'd0);
        settle();
        write_reg(pbrw_pkg::REG_DIR_ADDRESS, 64'h0000_fff8);
        push_beat(pbrw_pkg::CMD_START, 16'h0000, 64'd0);
        settle();
        write_reg(pbrw_pkg::REG_DIR_ADDRESS, 64'h0000_1000);
        write_reg(pbrw_pkg::REG_DIR_SIZE, 64'd4);
        push_beat(pbrw_pkg::CMD_START, 16'h0000, 64'd0);
        settle();
        write_reg(pbrw_pkg::REG_DIR_SIZE, 64'd24);
        settings_used++;
        // block at 0xf000 with a last-fitting target, then an empty block
        push_beat(pbrw_pkg::CMD_START, 16'h0000, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, 16'hf000, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, 16'h0000, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, 16'h0010, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, 16'h0000, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, {pbrw_pkg::TYPE_DIR64, 12'h000}, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, 16'hbeef, 64'd0);
        push_beat(pbrw_pkg::CMD_VALUE, 16'h0000, '1);
        push_beat(pbrw_pkg::CMD_HWORD, {pbrw_pkg::TYPE_ABSOLUTE, 12'h000}, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, {pbrw_pkg::TYPE_DIR64, 12'hff8}, 64'd0);
        push_beat(pbrw_pkg::CMD_VALUE, 16'h0000, 64'h0123_4567_89ab_cdef);
        push_beat(pbrw_pkg::CMD_HWORD, {pbrw_pkg::TYPE_ABSOLUTE, 12'h000}, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, 16'hffff, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, 16'hffff, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, 16'h0008, 64'd0);
        push_beat(pbrw_pkg::CMD_HWORD, 16'h0000, 64'd0);
        directed_beats = beats_sent;

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: img_size = 32'hffff_ffff;
                1: img_size = 32'h0000_2000;
                2: img_size = 32'h0001_0000;
                default: img_size = $urandom_range(32'h2000, 32'hffff_ffff);
            endcase
            case (p)
                0: delta_val = '1;
                1: delta_val = 64'd1;
                2: delta_val = 64'h8000_0000_0000_0000;
                default: delta_val = {$urandom, $urandom};
            endcase
            settle();
            write_reg(pbrw_pkg::REG_IMAGE_BYTES, {32'd0, img_size});
            write_reg(pbrw_pkg::REG_DELTA, delta_val);
            settings_used++;
            while (beats_sent < directed_beats + (p + 1) * RANDOM_BEATS / PHASES)
                play_run();
        end

        settle();
        $display("Covered %0d input beats in %0d random runs under %0d register settings;",
                 beats_sent, runs_sent, settings_used);
        $display("checked %0d patched words and %0d finished runs.", patch_total, finish_total);
        if (mismatch_total == 0 && backlog == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
